// ===== src/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg
// shared types and codes for the breakpoint address table
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

	localparam int unsigned ADDR_W = 64;

	// operation codes carried in the input tuser; code 3 is unused
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_MATCH  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_MISMATCH  = 2'd3
	} status_t;

	// one request to the slot array, applied when fire is set
	typedef struct packed {
		logic              fire;
		op_t               op;
		logic [ADDR_W-1:0] address;
		logic              kind_code;
	} req_t;

	typedef struct packed {
		status_t status;
		logic    hit;
	} rsp_t;

endpackage

`default_nettype wire

// ===== src/breakpoint_address_table.sv =====
// ----------------------------------------------------------------------------
// breakpoint_address_table
// table of software breakpoint slots with insert, remove and address match
// ----------------------------------------------------------------------------
// usage:
//   input stream (s_axis): one transfer per request. tdata carries the 64-bit
//   address, tuser carries the operation (insert, remove, match) and the
//   breakpoint kind (two-byte or four-byte).
//   output stream (m_axis): exactly one transfer per request, in order.
//   tdata carries the status code and the match hit flag.
// ordering: a request is registered in the input stage on acceptance and
//   compared against all slots there; its result is captured in the output
//   register once that register is free or drains, and m_axis_tvalid then
//   rises; while the output stays stalled the request waits in the input stage.
// throughput: one request per cycle while the output is not stalled; each
//   slot has its own comparator and its update is written in the same cycle
//   the result is registered, so the following request sees the new table.
// reset: arst_n clears every valid mark and empties both stages; slot
//   address and kind storage is not cleared and is only read once valid.
// stall: when m_axis_tready is low the result holds in the output register;
//   one more request can wait in the input stage, after which s_axis_tready
//   drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_address_table #(
	parameter int unsigned SLOT_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [63:0] address
	input  wire logic [2:0]  s_axis_tuser,   // [1:0] operation, [2] kind_code
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata    // [1:0] status, [2] hit, [7:3] zero
);
	import bat_pkg::*;

	// input stage
	logic              valid_s1;
	op_t               op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              kind_s1;

	// output register
	logic              out_valid_q;
	status_t           status_q;
	logic              hit_q;

	logic              in_xfer;
	logic              advance;
	req_t              req;
	rsp_t              rsp;

	// the input stage moves on whenever the output register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= op_t'(s_axis_tuser[1:0]);
			addr_s1 <= s_axis_tdata;
			kind_s1 <= s_axis_tuser[2];
		end
	end

	// the slot array commits its update only when the result is registered
	assign req = '{fire: advance, op: op_s1, address: addr_s1, kind_code: kind_s1};

	bat_slots #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= rsp.status;
			hit_q    <= rsp.hit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, hit_q, status_q};

	// a result waiting on the output must never be overwritten
	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !advance)
		else $error("output register overwritten while stalled");

	// a request held in the input stage is not replaced while stalled
	a_s1_held : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(addr_s1))
		else $error("input stage lost a request");

	// every retired request produces a visible result next cycle
	a_result_follows : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("result missing after commit");

endmodule

`default_nettype wire

// ===== src/bat_slots.sv =====
// ----------------------------------------------------------------------------
// bat_slots
// breakpoint slot storage with parallel address compare and priority pick
// ----------------------------------------------------------------------------
`default_nettype none

module bat_slots #(
	parameter int unsigned SLOT_COUNT = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bat_pkg::req_t req,
	output bat_pkg::rsp_t      rsp
);
	import bat_pkg::*;

	logic [SLOT_COUNT-1:0]  valid_q;
	logic [ADDR_W-1:0]      addr_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]  kind_q;

	logic [SLOT_COUNT-1:0]  free_vec;
	logic [SLOT_COUNT-1:0]  match_vec;
	logic [SLOT_COUNT-1:0]  free_first;
	logic [SLOT_COUNT-1:0]  match_first;
	logic                   first_kind;
	logic [SLOT_COUNT-1:0]  set_vec;
	logic [SLOT_COUNT-1:0]  clr_vec;

	localparam logic [SLOT_COUNT-1:0] ONE = {{(SLOT_COUNT-1){1'b0}}, 1'b1};

	// parallel compare, one comparator per slot
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match_vec[i] = valid_q[i] && (addr_q[i] == req.address);
		end
	end

	assign free_vec    = ~valid_q;
	// isolate the lowest set bit
	assign free_first  = free_vec & (~free_vec + ONE);
	assign match_first = match_vec & (~match_vec + ONE);
	assign first_kind  = |(match_first & kind_q);

	always_comb begin
		rsp     = '{status: ST_OK, hit: 1'b0};
		set_vec = '0;
		clr_vec = '0;
		case (req.op)
			OP_INSERT: begin
				if (|free_vec) begin
					set_vec = free_first;
				end else begin
					rsp.status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (!(|match_vec)) begin
					rsp.status = ST_NOT_FOUND;
				end else if (first_kind != req.kind_code) begin
					rsp.status = ST_MISMATCH;
				end else begin
					clr_vec = match_first;
				end
			end
			OP_MATCH: begin
				rsp.hit = |match_vec;
			end
			default: begin
				// unused code: no change, status ok
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.fire) begin
			valid_q <= (valid_q | set_vec) & ~clr_vec;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (req.fire && set_vec[i]) begin
				addr_q[i] <= req.address;
				kind_q[i] <= req.kind_code;
			end
		end
	end

	a_insert_fills_one : assert property (@(posedge clk) disable iff (!arst_n)
		req.fire && req.op == OP_INSERT && rsp.status == ST_OK
		|=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("insert did not fill exactly one slot");

	a_remove_clears_one : assert property (@(posedge clk) disable iff (!arst_n)
		req.fire && req.op == OP_REMOVE && rsp.status == ST_OK
		|=> $countones(valid_q) + 1 == $past($countones(valid_q)))
		else $error("remove did not clear exactly one slot");

	a_full_only_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		req.fire && rsp.status == ST_FULL |-> &valid_q)
		else $error("full reported with a free slot");

	a_idle_holds_valid : assert property (@(posedge clk) disable iff (!arst_n)
		!req.fire |=> $stable(valid_q))
		else $error("valid marks changed without a request");

endmodule

`default_nettype wire

// ===== dv/tb_breakpoint_address_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_breakpoint_address_table
// self-checking bench for the breakpoint slot table
// ----------------------------------------------------------------------------
// requests go in as insert, remove, match and the unused code over the input
// stream; a scoreboard keeps its own copy of the slot table, predicts the
// status and hit flag of every accepted request and compares them in order
// with what comes out of the result stream. a short directed run covers the
// corner cases, then random traffic swings the table between filling and
// draining while both sides of the handshake stall at random.
// ----------------------------------------------------------------------------

module tb_breakpoint_address_table;

	import bat_pkg::*;

	localparam int unsigned SLOT_COUNT   = 16;
	localparam int unsigned TOTAL_ITEMS  = 1400;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned SEGMENT      = 120;
	localparam int unsigned REPORT_MAX   = 10;

	// operation code 3 has no member in op_t, the block must ignore it
	localparam logic [1:0]  OP_UNUSED = 2'd3;

	localparam logic [63:0] ADDR_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ADDR_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [63:0] ADDR_ALT1 = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] ADDR_ALT0 = 64'h5555_5555_5555_5555;

	localparam bit KIND_TWO  = 1'b0;
	localparam bit KIND_FOUR = 1'b1;

	// ------------------------------------------------------------------------
	// scoreboard: shadow slot table plus the queue of predicted results
	// ------------------------------------------------------------------------
	class bp_scoreboard;
		bit          slot_valid [SLOT_COUNT];
		logic [63:0] slot_addr  [SLOT_COUNT];
		bit          slot_kind  [SLOT_COUNT];
		rsp_t        expected_rsp [$];
		int unsigned mismatches;
		int unsigned op_seen [4];
		int unsigned status_seen [4];
		int unsigned hits_seen;

		function new();
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			mismatches = 0;
			hits_seen  = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// apply one accepted request to the shadow table, queue its result
		function void note_request(logic [1:0] op, logic [63:0] addr, bit kind);
			rsp_t rsp;
			bit   searching;
			rsp.status = ST_OK;
			rsp.hit    = 1'b0;
			searching  = 1'b1;
			case (op)
			OP_INSERT: begin
				// lowest free slot wins, duplicates are allowed
				rsp.status = ST_FULL;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (searching && !slot_valid[i]) begin
						searching     = 1'b0;
						slot_valid[i] = 1'b1;
						slot_addr[i]  = addr;
						slot_kind[i]  = kind;
						rsp.status    = ST_OK;
					end
				end
			end
			OP_REMOVE: begin
				// only the lowest matching slot is looked at, kind decides
				rsp.status = ST_NOT_FOUND;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (searching && slot_valid[i] && slot_addr[i] == addr) begin
						searching = 1'b0;
						if (slot_kind[i] != kind) begin
							rsp.status = ST_MISMATCH;
						end else begin
							slot_valid[i] = 1'b0;
							rsp.status    = ST_OK;
						end
					end
				end
			end
			OP_MATCH: begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (slot_valid[i] && slot_addr[i] == addr)
						rsp.hit = 1'b1;
			end
			default: begin
				// unused code: no change, status ok, no hit
			end
			endcase
			op_seen[op]++;
			status_seen[rsp.status]++;
			if (rsp.hit)
				hits_seen++;
			expected_rsp.push_back(rsp);
		endfunction

		function void report(string what, rsp_t want, logic [7:0] got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("[%0t] result error (%s): expected status %0d hit %0d, got tdata 0x%02h",
					$time, what, want.status, want.hit, got);
		endfunction

		// compare one result transfer with the oldest prediction
		function void check_result(logic [7:0] data);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				want.status = ST_OK;
				want.hit    = 1'b0;
				report("no request outstanding", want, data);
				return;
			end
			want = expected_rsp.pop_front();
			if (data[1:0] !== want.status)
				report("status", want, data);
			else if (data[2] !== want.hit)
				report("hit", want, data);
			else if (data[7:3] !== 5'd0)
				report("padding bits", want, data);
		endfunction

		// pick the address of a random slot that is currently in use
		function bit pick_valid(output logic [63:0] addr);
			int used [$];
			addr = ADDR_ZERO;
			foreach (slot_valid[i])
				if (slot_valid[i])
					used.push_back(i);
			if (used.size() == 0)
				return 1'b0;
			addr = slot_addr[used[$urandom_range(used.size() - 1)]];
			return 1'b1;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block under test
	// ------------------------------------------------------------------------
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;    // [63:0] address
	logic [2:0]  s_axis_tuser  = '0;    // [1:0] operation, [2] kind_code
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // [1:0] status, [2] hit, [7:3] zero

	bp_scoreboard sb = new();

	// idle percentages, changed between traffic phases
	int unsigned send_gap_pct   = 19;
	int unsigned recv_stall_pct = 88;

	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;

	// a few well-known addresses mixed with random ones so that inserts,
	// removes and matches keep running into each other
	logic [63:0] addr_pool [16];

	always #5 clk = ~clk;

	breakpoint_address_table #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d results still outstanding",
				cycle_count, sb.expected_rsp.size());
			$display("breakpoint_address_table: mismatch");
			$finish;
		end
	end

	// result side backpressure, decided one cycle at a time
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	// both streams are sampled at the rising edge; the request is noted first
	// so a result can never overtake its own prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tuser[1:0], s_axis_tdata, s_axis_tuser[2]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// request driver: enters and leaves at a falling edge
	// ------------------------------------------------------------------------
	task automatic send_request(logic [1:0] op, logic [63:0] addr, bit kind);
		// random gap with junk on the data lines
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = {$urandom, $urandom};
			s_axis_tuser  = 3'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = addr;
		s_axis_tuser  = {kind, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] choose_address(int unsigned pct_valid,
		int unsigned pct_pool);
		logic [63:0] addr;
		int unsigned r;
		r = $urandom_range(99);
		if (r < pct_valid && sb.pick_valid(addr))
			return addr;
		if (r < pct_valid + pct_pool)
			return addr_pool[$urandom_range(15)];
		return {$urandom, $urandom};
	endfunction

	// random traffic; the table is pushed toward full and toward empty in
	// alternating segments so both the full case and misses show up often
	task automatic run_random(int unsigned count);
		int unsigned r;
		bit          fill_bias;
		logic [1:0]  op;
		logic [63:0] addr;
		for (int unsigned n = 0; n < count; n++) begin
			fill_bias = ((items_sent / SEGMENT) % 2) == 0;
			r = $urandom_range(99);
			if (r < (fill_bias ? 50 : 22))
				op = OP_INSERT;
			else if (r < (fill_bias ? 72 : 64))
				op = OP_REMOVE;
			else if (r < 98)
				op = OP_MATCH;
			else
				op = OP_UNUSED;
			case (op)
			OP_INSERT: addr = choose_address(0, 75);
			OP_REMOVE: addr = choose_address(55, 30);
			OP_MATCH:  addr = choose_address(40, 40);
			default:   addr = {$urandom, $urandom};
			endcase
			send_request(op, addr, 1'($urandom));
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned random_items;

		addr_pool[0] = ADDR_ZERO;
		addr_pool[1] = ADDR_ONES;
		addr_pool[2] = ADDR_ALT1;
		addr_pool[3] = ADDR_ALT0;
		for (int i = 4; i < 16; i++)
			addr_pool[i] = {$urandom, $urandom};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// phase one: sender gaps now and then, receiver mostly stalled
		send_gap_pct   = 19;
		recv_stall_pct = 88;

		// empty table: match misses, remove finds nothing
		send_request(OP_MATCH,  ADDR_ZERO, KIND_TWO);
		send_request(OP_REMOVE, ADDR_ZERO, KIND_TWO);
		// extreme addresses, and a duplicate insert into a second slot
		send_request(OP_INSERT, ADDR_ONES, KIND_FOUR);
		send_request(OP_INSERT, ADDR_ZERO, KIND_TWO);
		send_request(OP_INSERT, ADDR_ONES, KIND_FOUR);
		// wrong kind on the lowest copy is refused
		send_request(OP_REMOVE, ADDR_ONES, KIND_TWO);
		// unused code leaves the table alone
		send_request(OP_UNUSED, ADDR_ONES, KIND_FOUR);
		send_request(OP_REMOVE, ADDR_ONES, KIND_FOUR);
		// the duplicate in the higher slot still hits
		send_request(OP_MATCH,  ADDR_ONES, KIND_TWO);
		// reuse of the freed lowest slot
		send_request(OP_INSERT, ADDR_ALT0, KIND_FOUR);
		// kind mismatch at the lowest copy even though a higher copy fits
		send_request(OP_INSERT, ADDR_ALT1, KIND_TWO);
		send_request(OP_INSERT, ADDR_ALT1, KIND_FOUR);
		send_request(OP_REMOVE, ADDR_ALT1, KIND_FOUR);
		// fill up the rest of the table and run into the full case
		for (int k = 0; k < 12; k++)
			send_request(OP_INSERT, 64'h8000_0000_0000_0000 | 64'(k * 4), 1'(k));
		// full table: miss on remove, a hit, then free a slot
		send_request(OP_REMOVE, 64'h0000_0000_0000_0004, KIND_FOUR);
		send_request(OP_MATCH,  64'h8000_0000_0000_0014, KIND_TWO);
		send_request(OP_REMOVE, ADDR_ZERO, KIND_TWO);

		random_items = TOTAL_ITEMS - items_sent;
		run_random(random_items / 3);

		// phase two: roles of the two sides swapped
		send_gap_pct   = 88;
		recv_stall_pct = 19;
		run_random(random_items / 3);

		// phase three: back to back in both directions
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		run_random(random_items - 2 * (random_items / 3));

		s_axis_tvalid = 1'b0;

		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d insert, %0d remove, %0d match, %0d unused code",
			items_sent, sb.op_seen[OP_INSERT], sb.op_seen[OP_REMOVE],
			sb.op_seen[OP_MATCH], sb.op_seen[OP_UNUSED]);
		$display("outcomes: %0d ok, %0d table full, %0d not found, %0d kind clash, %0d hits",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND],
			sb.status_seen[ST_MISMATCH], sb.hits_seen);
		if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
			$display("breakpoint_address_table: match");
		end else begin
			$display("%0d result errors, %0d results missing",
				sb.mismatches, sb.expected_rsp.size());
			$display("breakpoint_address_table: mismatch");
		end
		$finish;
	end

endmodule
